/* sv/xlcr_pkg.sv */
// ----------------------------------------------------------------------------
// xlcr_pkg
// shared types and codes for the xor-linked cursor ring
// ----------------------------------------------------------------------------
package xlcr_pkg;

    localparam int ACT_W    = 2;
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_LEFT    = 2'd0,
        ACT_RIGHT   = 2'd1,
        ACT_REVERSE = 2'd2,
        ACT_INSERT  = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOV,
        S_INS,
        S_WC,
        S_WP,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;     // latch the incoming word
        logic rd_link;  // read links of cursor and trailing
        logic mov;      // walk update, read data at the new cursor
        logic wr_s;     // write spare node, work out the other two links
        logic wr_c;     // write cursor link
        logic wr_p;     // write trailing link, advance allocator, read data
        logic emit;     // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_act act;
        logic spare_ok;
        logic out_free;
    } t_sts;

endpackage

/* sv/xlcr_ctrl.sv */
// ----------------------------------------------------------------------------
// xlcr_ctrl
// sequencer for one action at a time: link read, update, writes, data read
// ----------------------------------------------------------------------------
module xlcr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  xlcr_pkg::t_sts i_sts,
    output xlcr_pkg::t_cmd o_cmd
);
    import xlcr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.act == ACT_INSERT && i_sts.spare_ok) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_MOV;
                end
            end
            S_MOV:   n_state = S_OUT;
            S_INS:   n_state = S_WC;
            S_WC:    n_state = S_WP;
            S_WP:    n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.take = i_s_valid;
            end
            S_RD:    o_cmd.rd_link = 1'b1;
            S_MOV:   o_cmd.mov     = 1'b1;
            S_INS:   o_cmd.wr_s    = 1'b1;
            S_WC:    o_cmd.wr_c    = 1'b1;
            S_WP:    o_cmd.wr_p    = 1'b1;
            S_OUT:   o_cmd.emit    = i_sts.out_free;
            default: o_cmd         = '0;
        endcase
    end

endmodule

/* sv/xlcr_dpath.sv */
// ----------------------------------------------------------------------------
// xlcr_dpath
// node pool memories, walker registers, allocator and output register
// ----------------------------------------------------------------------------
module xlcr_dpath #(
    parameter int NODES     = 256,
    parameter int DATA_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  xlcr_pkg::t_cmd           i_cmd,
    output xlcr_pkg::t_sts           o_sts,
    input  logic [xlcr_pkg::ACT_W-1:0]   i_act,
    input  logic [xlcr_pkg::VALUE_W-1:0] i_value,
    input  logic                     i_m_ready,
    output logic                     o_m_valid,
    output logic [xlcr_pkg::VALUE_W-1:0] o_m_data,
    output logic [xlcr_pkg::INDEX_W-1:0] o_m_index,
    output logic                     o_m_status
);
    import xlcr_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [IW:0] NodesW = (IW+1)'(NODES);

    // pool memories, one write and up to two reads a cycle
    logic [IW-1:0]        link_mem [NODES];
    logic [DATA_BITS-1:0] data_mem [NODES];

    // walker and allocator state
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_trl;
    logic [IW-1:0] r_spare;
    logic          r_spare_ok;
    logic [IW:0]   r_next;
    // node zero reads as zero until first written
    logic          r_l0_wr;
    logic          r_d0_wr;

    // latched input word
    t_act                 r_act;
    logic [DATA_BITS-1:0] r_val;

    // read data
    logic [IW-1:0]        r_la_q;
    logic [IW-1:0]        r_lb_q;
    logic                 r_la_zero;
    logic                 r_lb_zero;
    logic [DATA_BITS-1:0] r_d_q;
    logic                 r_d_zero;

    // insert link values for the later writes
    logic [IW-1:0] r_lc;
    logic [IW-1:0] r_lp;
    logic          r_status;

    // output register
    logic                 r_m_valid;
    logic [DATA_BITS-1:0] r_m_data;
    logic [IW-1:0]        r_m_cur;
    logic                 r_m_status;

    logic [IW-1:0]        la;
    logic [IW-1:0]        lb;
    logic [DATA_BITS-1:0] dq;
    logic [IW-1:0]        rd_a_addr;
    logic [IW-1:0]        mv_cur;
    logic [IW-1:0]        mv_trl;
    logic [IW-1:0]        ls;
    logic [IW-1:0]        lc0;
    logic [IW-1:0]        lc;
    logic [IW-1:0]        lp0;
    logic [IW-1:0]        lp;
    logic                 lw_en;
    logic [IW-1:0]        lw_addr;
    logic [IW-1:0]        lw_data;
    logic [IW-1:0]        d_rd_addr;
    logic [IW+INDEX_W-1:0] cur_ext;

    assign la = r_la_zero ? '0 : r_la_q;
    assign lb = r_lb_zero ? '0 : r_lb_q;
    assign dq = r_d_zero  ? '0 : r_d_q;

    // move left needs the link of the trailing node, the others of the cursor
    assign rd_a_addr = (r_act == ACT_LEFT) ? r_trl : r_cur;

    always_comb begin
        mv_cur = r_cur;
        mv_trl = r_trl;
        case (r_act)
            ACT_LEFT: begin
                mv_cur = r_trl;
                mv_trl = r_cur ^ la;
            end
            ACT_RIGHT: begin
                mv_cur = r_trl ^ la;
                mv_trl = r_cur;
            end
            ACT_REVERSE: mv_trl = r_trl ^ la;
            default: begin
                mv_cur = r_cur;
                mv_trl = r_trl;
            end
        endcase
    end

    // insert links, each seeing the writes before it when nodes alias
    always_comb begin
        ls  = r_trl ^ r_cur;
        lc0 = (r_cur == r_spare) ? ls : la;
        lc  = lc0 ^ r_trl ^ r_spare;
        if (r_trl == r_cur) begin
            lp0 = lc;
        end else if (r_trl == r_spare) begin
            lp0 = ls;
        end else begin
            lp0 = lb;
        end
        lp = lp0 ^ r_cur ^ r_spare;
    end

    always_comb begin
        lw_en   = i_cmd.wr_s | i_cmd.wr_c | i_cmd.wr_p;
        lw_addr = r_spare;
        lw_data = ls;
        if (i_cmd.wr_c) begin
            lw_addr = r_cur;
            lw_data = r_lc;
        end else if (i_cmd.wr_p) begin
            lw_addr = r_trl;
            lw_data = r_lp;
        end
    end

    assign d_rd_addr = i_cmd.mov ? mv_cur : r_cur;

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        if (i_cmd.rd_link) begin
            r_la_q <= link_mem[rd_a_addr];
            r_lb_q <= link_mem[r_trl];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_s) begin
            data_mem[r_spare] <= r_val;
        end
        if (i_cmd.mov || i_cmd.wr_p) begin
            r_d_q <= data_mem[d_rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_act <= t_act'(i_act);
            r_val <= i_value[DATA_BITS-1:0];
        end
        if (i_cmd.rd_link) begin
            r_la_zero <= (rd_a_addr == '0) && !r_l0_wr;
            r_lb_zero <= (r_trl == '0) && !r_l0_wr;
        end
        if (i_cmd.mov || i_cmd.wr_p) begin
            r_d_zero <= (d_rd_addr == '0) && !r_d0_wr;
            r_status <= i_cmd.mov && (r_act == ACT_INSERT);
        end
        if (i_cmd.wr_s) begin
            r_lc <= lc;
            r_lp <= lp;
        end
        if (i_cmd.emit) begin
            r_m_data   <= dq;
            r_m_cur    <= r_cur;
            r_m_status <= r_status;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_trl      <= '0;
            r_spare    <= '0;
            r_spare_ok <= 1'b1;
            r_next     <= (IW+1)'(1);
            r_l0_wr    <= 1'b0;
            r_d0_wr    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cmd.mov) begin
                r_cur <= mv_cur;
                r_trl <= mv_trl;
            end
            if (i_cmd.wr_p) begin
                r_trl <= r_spare;
                if (r_next < NodesW) begin
                    r_spare <= r_next[IW-1:0];
                    r_next  <= r_next + (IW+1)'(1);
                end else begin
                    r_spare_ok <= 1'b0;
                end
            end
            if (lw_en && lw_addr == '0) begin
                r_l0_wr <= 1'b1;
            end
            if (i_cmd.wr_s && r_spare == '0) begin
                r_d0_wr <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_sts.act      = r_act;
    assign o_sts.spare_ok = r_spare_ok;
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    assign cur_ext    = {{INDEX_W{1'b0}}, r_m_cur};
    assign o_m_valid  = r_m_valid;
    assign o_m_data   = VALUE_W'(r_m_data);
    assign o_m_index  = cur_ext[INDEX_W-1:0];
    assign o_m_status = r_m_status;

endmodule

/* sv/xor_link_cursor_ring_top.sv */
// ----------------------------------------------------------------------------
// xor_link_cursor_ring_top
// circular xor-linked list walker over a fixed node pool
// ----------------------------------------------------------------------------
// Each accepted word carries an action (move left, move right, reverse, insert)
// and a data value; each gives one result word with the data and index of the
// node at the cursor and a refusal flag for an insert on an exhausted pool.
// One word is worked on at a time. Moves, reverses and refused inserts go
// through acceptance, link read, walker update with data read and output
// load; inserts go through acceptance, link read, then the three link writes
// of the spare, cursor and trailing nodes one by one through the single write
// port of the link memory, and output load. The output load waits while the
// output register holds a result not yet taken. The next word is taken once
// the result is in the output register. Node zero reads as zero in both
// memories until it is first written, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module xor_link_cursor_ring_top #(
    parameter int NODES     = 256,
    parameter int DATA_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value[63:0]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // cursor_data[63:0], cursor_index[71:64]
    output logic [0:0]  m_axis_tuser    // status[0]
);
    import xlcr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    logic [VALUE_W-1:0] m_data;
    logic [INDEX_W-1:0] m_index;
    logic               m_status;

    xlcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    xlcr_dpath #(
        .NODES     (NODES),
        .DATA_BITS (DATA_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_act      (s_axis_tuser),
        .i_value    (s_axis_tdata),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_m_data   (m_data),
        .o_m_index  (m_index),
        .o_m_status (m_status)
    );

    assign m_axis_tdata = {m_index, m_data};
    assign m_axis_tuser = m_status;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the xor-linked cursor ring walker
// ----------------------------------------------------------------------------
// A short stimulus table (reset state, extreme data words, every action, the
// aliased inserts on a one- and two-node ring) is followed by random words,
// weighted towards inserts at first so that the node pool runs dry and the
// refusal path is exercised. A behavioural ring copy predicts the results not
// given in the table, and all are matched in order. Both sides of the stream
// idle at random, with calm stretches and full drains in between.
// ----------------------------------------------------------------------------
module tb;
    import xlcr_pkg::*;

    localparam int POOL       = 256;
    localparam int RAND_WORDS = 650;

    typedef struct packed {
        logic [63:0] data;
        logic [7:0]  index;
        logic        status;
    } t_report;

    typedef struct {
        t_act        act;
        logic [63:0] value;
        bit          typed;
        t_report     rep;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // value[63:0]
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // cursor_data[63:0], cursor_index[71:64]
    logic [0:0]  m_axis_tuser;   // status[0]

    // ring copy used for prediction
    logic [7:0]  ring_link [POOL];
    logic [63:0] ring_word [POOL];
    logic [7:0]  walk_cur;
    logic [7:0]  walk_trail;
    logic [7:0]  spare_node;
    logic        spare_ok;
    logic [8:0]  next_free;

    t_report     cursor_reports_q[$];
    t_row        plan[$];
    int          errors       = 0;
    int          words_sent   = 0;
    int          results_seen = 0;

    xor_link_cursor_ring_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb failed");
        $finish;
    end

    function automatic t_report walk_ring(input t_act act, input logic [63:0] value);
        logic [7:0] s;
        logic [7:0] p;
        logic [7:0] c;
        t_report    r;
        r.status = 1'b0;
        case (act)
            ACT_LEFT: begin
                c = walk_cur;
                walk_cur = walk_trail;
                walk_trail = c ^ ring_link[walk_cur];
            end
            ACT_RIGHT: begin
                p = walk_trail ^ ring_link[walk_cur];
                walk_trail = walk_cur;
                walk_cur = p;
            end
            ACT_REVERSE: begin
                walk_trail = walk_trail ^ ring_link[walk_cur];
            end
            default: begin
                if (!spare_ok) begin
                    r.status = 1'b1;
                end else begin
                    s = spare_node;
                    p = walk_trail;
                    c = walk_cur;
                    // order matters when the nodes alias
                    ring_word[s] = value;
                    ring_link[s] = p ^ c;
                    ring_link[c] = ring_link[c] ^ p ^ s;
                    ring_link[p] = ring_link[p] ^ c ^ s;
                    walk_trail = s;
                    if (next_free < POOL) begin
                        spare_node = next_free[7:0];
                        next_free = next_free + 9'd1;
                    end else begin
                        spare_ok = 1'b0;
                    end
                end
            end
        endcase
        r.data  = ring_word[walk_cur];
        r.index = walk_cur;
        return r;
    endfunction

    task automatic add_row(input t_act act, input logic [63:0] value, input bit typed,
                           input logic [63:0] d, input logic [7:0] ix, input logic st);
        t_row row;
        row.act = act;
        row.value = value;
        row.typed = typed;
        row.rep.data = d;
        row.rep.index = ix;
        row.rep.status = st;
        plan.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic offer_word(input t_act act, input logic [63:0] value,
                              input bit typed, input t_report typed_rep);
        int      gap;
        t_report rep;
        gap = (((words_sent / 40) % 4) == 3) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        rep = walk_ring(act, value);
        cursor_reports_q.push_back(typed ? typed_rep : rep);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (cursor_reports_q.size() != 0);
    endtask

    task automatic check_report();
        t_report want;
        if (cursor_reports_q.size() == 0) begin
            $error("result word with no expectation: data %h index %h status %b",
                   m_axis_tdata[63:0], m_axis_tdata[71:64], m_axis_tuser[0]);
            errors++;
        end else begin
            want = cursor_reports_q.pop_front();
            if (m_axis_tdata[63:0] !== want.data) begin
                $error("cursor_data mismatch: expected %h, got %h",
                       want.data, m_axis_tdata[63:0]);
                errors++;
            end
            if (m_axis_tdata[71:64] !== want.index) begin
                $error("cursor_index mismatch: expected %h, got %h",
                       want.index, m_axis_tdata[71:64]);
                errors++;
            end
            if (m_axis_tuser[0] !== want.status) begin
                $error("status mismatch: expected %b, got %b", want.status, m_axis_tuser[0]);
                errors++;
            end
        end
    endtask

    // result side
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = (((results_seen / 40) % 4) == 1) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_report();
            results_seen++;
            @(negedge i_clk);
        end
    end

    // stimulus side
    initial begin
        t_act        act;
        logic [63:0] value;
        int          pick;
        int          waited;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_LEFT;

        for (int i = 0; i < POOL; i++) begin
            ring_link[i] = '0;
            ring_word[i] = '0;
        end
        walk_cur   = '0;
        walk_trail = '0;
        spare_node = '0;
        spare_ok   = 1'b1;
        next_free  = 9'd1;

        // single node ring at reset, node zero is also the spare
        add_row(ACT_LEFT,    64'h0,                  1, 64'h0, 8'h00, 1'b0);
        add_row(ACT_RIGHT,   64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 8'h00, 1'b0);
        add_row(ACT_REVERSE, 64'h0,                  1, 64'h0, 8'h00, 1'b0);
        add_row(ACT_INSERT,  64'hFFFF_FFFF_FFFF_FFFF, 1,
                64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
        add_row(ACT_INSERT,  64'h0,                  1,
                64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
        add_row(ACT_RIGHT,   64'h1234_5678_9ABC_DEF0, 0, '0, '0, 1'b0);
        add_row(ACT_LEFT,    64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_INSERT,  64'h5555_5555_5555_5555, 0, '0, '0, 1'b0);
        add_row(ACT_REVERSE, 64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_INSERT,  64'hAAAA_AAAA_AAAA_AAAA, 0, '0, '0, 1'b0);
        add_row(ACT_RIGHT,   64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_RIGHT,   64'hFFFF_FFFF_FFFF_FFFF, 0, '0, '0, 1'b0);
        add_row(ACT_RIGHT,   64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_LEFT,    64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_LEFT,    64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_REVERSE, 64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_INSERT,  64'h0000_0000_0000_0001, 0, '0, '0, 1'b0);
        add_row(ACT_INSERT,  64'h8000_0000_0000_0000, 0, '0, '0, 1'b0);
        add_row(ACT_RIGHT,   64'h0,                  0, '0, '0, 1'b0);
        add_row(ACT_LEFT,    64'h0,                  0, '0, '0, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            offer_word(plan[k].act, plan[k].value, plan[k].typed, plan[k].rep);
        end
        hold_until_drained();

        // insert-heavy start so the pool runs dry, then an even mix
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i < 400) begin
                pick = $urandom_range(0, 9);
                act = (pick < 6) ? ACT_INSERT : t_act'($urandom_range(0, 2));
            end else begin
                act = t_act'($urandom_range(0, 3));
            end
            value = {$urandom, $urandom};
            offer_word(act, value, 1'b0, '0);
            if ((i % 150) == 149) begin
                hold_until_drained();
            end
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (cursor_reports_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (cursor_reports_q.size() != 0) begin
            $error("%0d result words never arrived", cursor_reports_q.size());
            errors++;
        end
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/xlcr_pkg.sv
sv/xlcr_ctrl.sv
sv/xlcr_dpath.sv
sv/xor_link_cursor_ring_top.sv
bench/tb.sv
